### design/irc_pkg.sv
package irc_pkg;

  localparam int MAX_TAPS  = 2048;
  localparam int PART_SIZE = 32;

  localparam int TAP_AW   = $clog2(MAX_TAPS);
  localparam int CNT_W    = TAP_AW + 1;
  localparam int LAT_AW   = $clog2(PART_SIZE);
  localparam int SMP_W    = 24;
  localparam int PROD_W   = 2 * SMP_W;
  localparam int ACC_W    = PROD_W + CNT_W;
  localparam int ROUND_SH = 22;
  localparam int LEN_W    = 12;

  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_IR_LENGTH = '0;

  localparam logic [CNT_W-1:0] MAX_TAPS_C = CNT_W'(MAX_TAPS);
  localparam logic [LAT_AW-1:0] LAT_FULL  = LAT_AW'(PART_SIZE - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SMP_W + 1){1'b0}}, {(SMP_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - SMP_W + 1){1'b1}}, {(SMP_W - 1){1'b0}}};
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (ROUND_SH - 1);

  typedef enum logic [1:0] {
    OP_TAP    = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [TAP_AW-1:0]        tap_index;
    logic signed [SMP_W-1:0]  tap_value;
    logic signed [SMP_W-1:0]  sample_in;
  } irc_cmd_t;

  typedef struct packed {
    logic             clr;
    logic [LEN_W-1:0] ir_length;
  } irc_cfg_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROUND = 5'b01000,
    S_OUT   = 5'b10000
  } back_state_e;

endpackage

### design/irc_if.sv
interface irc_in_if;
  import irc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [TAP_AW-1:0]        tap_index;
  logic signed [SMP_W-1:0]  tap_value;
  logic signed [SMP_W-1:0]  sample_in;

  modport source (output valid, output op, output tap_index, output tap_value,
                  output sample_in, input ready);
  modport sink (input valid, input op, input tap_index, input tap_value,
                input sample_in, output ready);
endinterface

interface irc_out_if;
  import irc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

### design/irc_front.sv
module irc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  irc_in_if.sink            in_i,
  output logic              cmd_valid_o,
  output irc_pkg::irc_cmd_t cmd_o,
  input  logic              cmd_pop_i
);
  import irc_pkg::*;

  irc_cmd_t   fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  irc_cmd_t   cmd_in;

  assign in_i.ready = (cnt_q != 2'd2);

  // Drop unused op codes: accept the word, queue nothing.
  assign push = in_i.valid && in_i.ready &&
                (in_i.op == OP_TAP || in_i.op == OP_SAMPLE || in_i.op == OP_CLEAR);
  assign pop  = cmd_pop_i && (cnt_q != 2'd0);

  always_comb begin
    cmd_in.op        = op_e'(in_i.op);
    cmd_in.tap_index = in_i.tap_index;
    cmd_in.tap_value = in_i.tap_value;
    cmd_in.sample_in = in_i.sample_in;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

endmodule

### design/irc_back.sv
module irc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irc_pkg::irc_cfg_t cfg_i,
  input  logic              cmd_valid_i,
  input  irc_pkg::irc_cmd_t cmd_i,
  output logic              cmd_pop_o,
  irc_out_if.source         out_o
);
  import irc_pkg::*;

  logic signed [SMP_W-1:0] tap_mem  [MAX_TAPS];
  logic signed [SMP_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SMP_W-1:0] lat_q    [PART_SIZE];

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]  eff_len;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [TAP_AW-1:0] hp_q, hp_d;
  logic [LAT_AW-1:0] lp_q, lp_d;
  logic [LAT_AW-1:0] lat_cnt_q, lat_cnt_d;

  logic tap_we, hist_we, issue, lat_we;
  logic p1_vld_q, p1_live_q, p2_vld_q;
  logic signed [SMP_W-1:0]  tap_rd_q, hist_rd_q;
  logic signed [PROD_W-1:0] prod_full, prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     acc_clr;
  logic signed [ACC_W-1:0]  rnd_sum, rnd_sh;
  logic signed [SMP_W-1:0]  res_q, res_d;
  logic [TAP_AW-1:0]        hist_rd_addr;
  logic [LAT_AW-1:0]        lat_rd_addr;

  logic                    out_free, out_load;
  logic                    out_valid_q;
  logic signed [SMP_W-1:0] out_data_q, out_data_d;

  assign eff_len = (cfg_i.ir_length > LEN_W'(MAX_TAPS)) ? MAX_TAPS_C
                                                        : CNT_W'(cfg_i.ir_length);
  assign out_free     = !out_valid_q || out_o.ready;
  assign hist_rd_addr = hp_q - k_q[TAP_AW-1:0];
  assign lat_rd_addr  = LAT_AW'(lp_q + 1'b1);
  assign issue        = (state_q == S_MAC);

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    fill_d     = fill_q;
    hp_d       = hp_q;
    lp_d       = lp_q;
    lat_cnt_d  = lat_cnt_q;
    tap_we     = 1'b0;
    hist_we    = 1'b0;
    lat_we     = 1'b0;
    acc_clr    = 1'b0;
    cmd_pop_o  = 1'b0;
    out_load   = 1'b0;
    out_data_d = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_TAP: begin
              tap_we    = 1'b1;
              cmd_pop_o = 1'b1;
            end
            OP_CLEAR: begin
              fill_d    = '0;
              hp_d      = '0;
              lp_d      = '0;
              lat_cnt_d = '0;
              cmd_pop_o = 1'b1;
            end
            OP_SAMPLE: begin
              if (eff_len == '0) begin
                // Passthrough: leave history and delay line alone.
                if (out_free) begin
                  out_load   = 1'b1;
                  out_data_d = cmd_i.sample_in;
                  cmd_pop_o  = 1'b1;
                end
              end else begin
                hist_we   = 1'b1;
                acc_clr   = 1'b1;
                k_d       = '0;
                fill_d    = (fill_q == MAX_TAPS_C) ? fill_q : CNT_W'(fill_q + 1'b1);
                cmd_pop_o = 1'b1;
                state_d   = S_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        k_d = CNT_W'(k_q + 1'b1);
        if (k_d == eff_len) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_vld_q && !p2_vld_q) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          lat_we     = 1'b1;
          out_load   = 1'b1;
          out_data_d = (lat_cnt_q == LAT_FULL) ? lat_q[lat_rd_addr] : '0;
          lp_d       = LAT_AW'(lp_q + 1'b1);
          lat_cnt_d  = (lat_cnt_q == LAT_FULL) ? lat_cnt_q : LAT_AW'(lat_cnt_q + 1'b1);
          hp_d       = TAP_AW'(hp_q + 1'b1);
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Register write resets history, as op CLEAR does; the user keeps writes to idle, the block leaves this unchecked.
    if (cfg_i.clr) begin
      fill_d    = '0;
      hp_d      = '0;
      lp_d      = '0;
      lat_cnt_d = '0;
    end
  end

  // Round half away from zero, then saturate to Q1.23.
  assign rnd_sum = acc_q + (acc_q[ACC_W-1] ? ACC_W'(RND_HALF - 1'b1) : RND_HALF);
  assign rnd_sh  = rnd_sum >>> ROUND_SH;

  always_comb begin
    if (rnd_sh > SAT_HI) begin
      res_d = SAT_HI[SMP_W-1:0];
    end else if (rnd_sh < SAT_LO) begin
      res_d = SAT_LO[SMP_W-1:0];
    end else begin
      res_d = rnd_sh[SMP_W-1:0];
    end
  end

  assign prod_full = tap_rd_q * hist_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      fill_q      <= '0;
      hp_q        <= '0;
      lp_q        <= '0;
      lat_cnt_q   <= '0;
      p1_vld_q    <= 1'b0;
      p1_live_q   <= 1'b0;
      p2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      fill_q    <= fill_d;
      hp_q      <= hp_d;
      lp_q      <= lp_d;
      lat_cnt_q <= lat_cnt_d;
      p1_vld_q  <= issue;
      p1_live_q <= issue && (k_q < fill_q);
      p2_vld_q  <= p1_vld_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[cmd_i.tap_index] <= cmd_i.tap_value;
    end
    tap_rd_q <= tap_mem[k_q[TAP_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hp_q] <= cmd_i.sample_in;
    end
    hist_rd_q <= hist_mem[hist_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= p1_live_q ? prod_full : '0;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (p2_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (state_q == S_ROUND) begin
      res_q <= res_d;
    end
    if (lat_we) begin
      lat_q[lp_q] <= res_q;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

### design/impulse_response_convolver.sv
// A sample runs min(ir_length, 2048) MACs, one per tap through the tap and
//   history memory ports, then the drain, round and output states; tap load,
//   clear and passthrough are handled in the idle state. The engine takes a
//   new sample only once the last one has passed the output state.
// Reset (async, active low) clears control, pointers, fill counts and
//   ir_length; tap memory holds garbage until loaded.
module impulse_response_convolver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  irc_in_if.sink                       in_i,
  irc_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irc_pkg::APB_AW-1:0]   paddr,
  input  logic [irc_pkg::APB_DW-1:0]   pwdata,
  output logic [irc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import irc_pkg::*;

  logic [LEN_W-1:0]     ir_length_q, ir_length_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_we;
  irc_cfg_t             cfg;
  logic                 cmd_valid;
  logic                 cmd_pop;
  irc_cmd_t             cmd;

  // APB register file: a single register, ir_length, at byte address 0.
  // Writes land on the access phase; reads are combinational.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign reg_we  = psel && penable && pwrite && (reg_idx == REG_IR_LENGTH);

  assign ir_length_d = reg_we ? pwdata[LEN_W-1:0] : ir_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_length_q <= '0;
    end else begin
      ir_length_q <= ir_length_d;
    end
  end

  assign prdata = (reg_idx == REG_IR_LENGTH) ? APB_DW'(ir_length_q) : '0;

  // A write to ir_length also flushes the history and the delay line.
  assign cfg.clr       = reg_we;
  assign cfg.ir_length = ir_length_q;

  // Front: accept words, drop unused op codes, buffer in a two-entry queue.
  irc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: tap and history memories, serial MAC, round/saturate, the
  // PART_SIZE-1 delay line and the output register.
  irc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o)
  );

endmodule

### design/irc_checker.sv
module irc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [irc_pkg::SMP_W-1:0]  sample_out,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [irc_pkg::APB_AW-1:0]        paddr,
  input logic [irc_pkg::APB_DW-1:0]        pwdata,
  input logic [irc_pkg::APB_DW-1:0]        prdata
);
  import irc_pkg::*;

  // Hold a stalled output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("output word dropped or changed while stalled");

  // No output word while in reset.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("output valid during reset");

  // Written ir_length reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_IR_LENGTH) |=>
    (paddr[APB_AW-1:2] != REG_IR_LENGTH ||
     prdata == APB_DW'($past(pwdata[LEN_W-1:0]))))
    else $error("ir_length readback mismatch");

  // Unused register bits read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[APB_DW-1:LEN_W] == '0)
    else $error("reserved register bits not zero");

endmodule

bind impulse_response_convolver irc_checker u_irc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .sample_out (out_o.sample_out),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);

### tb/sv/irc_checker.sv
module irc_scoreboard (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  irc_in_if                            in_i,
  irc_out_if                           out_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [irc_pkg::APB_AW-1:0]   paddr,
  input  logic [irc_pkg::APB_DW-1:0]   pwdata,
  output int                           mismatch_cnt_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import irc_pkg::*;

  localparam logic signed [SMP_W-1:0] Q23_MAX = 24'sh7fffff;
  localparam logic signed [SMP_W-1:0] Q23_MIN = 24'sh800000;

  logic signed [SMP_W-1:0] tap_coeff  [MAX_TAPS];
  logic signed [SMP_W-1:0] hist_buf   [MAX_TAPS];
  logic signed [SMP_W-1:0] delay_line [PART_SIZE];
  logic [TAP_AW-1:0]       hist_wr_ptr;
  logic [LAT_AW-1:0]       delay_ptr;
  logic [LEN_W-1:0]        ir_len_q;

  logic signed [SMP_W-1:0] expected_out_q [$];
  logic signed [SMP_W-1:0] want_sample;
  int                      mismatch_cnt;

  task automatic clear_history();
    foreach (hist_buf[i]) hist_buf[i] = '0;
    foreach (delay_line[i]) delay_line[i] = '0;
    hist_wr_ptr = '0;
    delay_ptr   = '0;
  endtask

  // Compute the output word, if any, that one accepted input word causes.
  task automatic predict_word(input logic [1:0] op, input logic [TAP_AW-1:0] idx,
                              input logic signed [SMP_W-1:0] tv,
                              input logic signed [SMP_W-1:0] si);
    longint                  acc;
    longint                  mag;
    longint                  rounded;
    int                      taps_used;
    logic [TAP_AW-1:0]       slot;
    logic signed [SMP_W-1:0] y;
    case (op)
      OP_TAP: tap_coeff[idx] = tv;
      OP_CLEAR: clear_history();
      OP_SAMPLE: begin
        if (ir_len_q == '0) begin
          expected_out_q = {expected_out_q, si};
        end else begin
          taps_used = (ir_len_q > MAX_TAPS) ? MAX_TAPS : int'(ir_len_q);
          hist_buf[hist_wr_ptr] = si;
          acc = 0;
          for (int k = 0; k < taps_used; k++) begin
            slot = hist_wr_ptr - TAP_AW'(k);
            acc += longint'(tap_coeff[k]) * longint'(hist_buf[slot]);
          end
          hist_wr_ptr = hist_wr_ptr + 1'b1;
          // doubled Q1.23: round half away from zero, then clamp
          mag     = (acc < 0) ? -acc : acc;
          rounded = (mag + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
          if (acc < 0) rounded = -rounded;
          if (rounded > longint'(Q23_MAX)) y = Q23_MAX;
          else if (rounded < longint'(Q23_MIN)) y = Q23_MIN;
          else y = SMP_W'(rounded);
          delay_line[delay_ptr] = y;
          expected_out_q = {expected_out_q, delay_line[LAT_AW'(delay_ptr + 1'b1)]};
          delay_ptr = delay_ptr + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_history();
      ir_len_q = '0;
      expected_out_q.delete();
      mismatch_cnt = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_out_q.size() == 0) begin
          $error("sample_out: no word expected, got %0d", out_i.sample_out);
          mismatch_cnt++;
        end else begin
          want_sample = expected_out_q.pop_front();
          if (out_i.sample_out !== want_sample) begin
            $error("sample_out: expected %0d, got %0d", want_sample, out_i.sample_out);
            mismatch_cnt++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_IR_LENGTH) begin
        ir_len_q = pwdata[LEN_W-1:0];
        clear_history();
      end
      if (in_i.valid && in_i.ready)
        predict_word(in_i.op, in_i.tap_index, in_i.tap_value, in_i.sample_in);
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_o      <= expected_out_q.size();
  end

endmodule

### tb/sv/impulse_response_convolver_tb.sv
module impulse_response_convolver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irc_pkg::*;

  localparam logic signed [SMP_W-1:0] Q23_MAX = 24'sh7fffff;
  localparam logic signed [SMP_W-1:0] Q23_MIN = 24'sh800000;
  localparam logic signed [SMP_W-1:0] HALF_LSB = 24'sd2097152;  // 0.5 at the doubled lsb
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One sample runs a MAC per tap, up to MAX_TAPS; leave margin for
  // queued no-result words behind it.
  localparam int SETTLE_CYCLES       = MAX_TAPS + 64;
  localparam int BACKPRESSURE_CYCLES = 500;
  localparam int WATCHDOG_LIMIT      = 10000;
  localparam int NUM_PHASES          = 5;
  localparam int LOADED_TAPS         = 64;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int mismatch_cnt;
  int words_pending;
  int idle_cycles = 0;
  bit calm        = 1'b0;  // no random gaps on either side while set
  bit hold_req    = 1'b0;  // ask the receiver for one long hold-off

  irc_in_if  in_w ();
  irc_out_if out_w ();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  impulse_response_convolver u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_w),
    .out_o   (out_w),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  irc_scoreboard u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_w),
    .out_i          (out_w),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (words_pending)
  );

  // Draw a Q1.23 value: extremes, small magnitudes and full-scale noise.
  function automatic logic signed [SMP_W-1:0] pick_q23();
    logic signed [SMP_W-1:0] v;
    v = SMP_W'($urandom);
    case ($urandom_range(0, 7))
      0: v = Q23_MAX;
      1: v = Q23_MIN;
      2: v = v >>> 12;
      3: v = v >>> $urandom_range(1, 8);
      default: ;
    endcase
    return v;
  endfunction

  // Offer one word and hold it until accepted. Keep valid high when the
  // next word follows directly; drop it only for a random gap.
  task automatic send_word(input logic [1:0] op, input logic [TAP_AW-1:0] idx,
                           input logic signed [SMP_W-1:0] tv,
                           input logic signed [SMP_W-1:0] si);
    int gap;
    in_w.valid     <= 1'b1;
    in_w.op        <= op;
    in_w.tap_index <= idx;
    in_w.tap_value <= tv;
    in_w.sample_in <= si;
    do @(posedge clk_i); while (!in_w.ready);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write ir_length only once the block is idle: every expected word out,
  // then enough cycles for any queued tap loads or clears to retire.
  task automatic set_ir_length(input int len);
    in_w.valid <= 1'b0;
    while (words_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IR_LENGTH, 2'b00};
    pwdata  <= APB_DW'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and stalls its input while the sender keeps offering.
  initial begin
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = BACKPRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        out_w.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_w.ready <= 1'b0;
        gap_left--;
      end else begin
        out_w.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 15);
      end
    end
  end

  // Watchdog: end the run if no word and no register access moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL impulse_response_convolver");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int plan_len [NUM_PHASES];
    int plan_cnt [NUM_PHASES];
    int n;
    int r;
    logic [TAP_AW-1:0] idx;

    rst_ni         <= 1'b0;
    in_w.valid     <= 1'b0;
    in_w.op        <= OP_TAP;
    in_w.tap_index <= '0;
    in_w.tap_value <= '0;
    in_w.sample_in <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Passthrough after reset: extremes and other values go through, unchanged.
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), Q23_MAX);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), Q23_MIN);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), -24'sd1);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), 24'sd0);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), 24'sh555555);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), 24'shaaaaaa);
    send_word(OP_CLEAR, TAP_AW'($urandom), SMP_W'($urandom), SMP_W'($urandom));
    send_word(OP_UNUSED, TAP_AW'($urandom), SMP_W'($urandom), SMP_W'($urandom));
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), 24'sd1);

    // Load the leading taps; every length used below stays within them.
    for (int i = 0; i < LOADED_TAPS; i++)
      send_word(OP_TAP, TAP_AW'(i), pick_q23(), SMP_W'($urandom));

    // Single tap: saturation both ways, then rounding ties and near-ties.
    set_ir_length(1);
    send_word(OP_TAP, '0, Q23_MAX, SMP_W'($urandom));
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), Q23_MAX);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), Q23_MIN);
    send_word(OP_TAP, '0, Q23_MIN, SMP_W'($urandom));
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), Q23_MAX);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), Q23_MIN);
    send_word(OP_TAP, '0, 24'sd1, SMP_W'($urandom));
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), HALF_LSB);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), -HALF_LSB);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), HALF_LSB - 24'sd1);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), 24'sd1 - HALF_LSB);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), 24'sd3 * HALF_LSB);
    send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), -24'sd3 * HALF_LSB);

    // Random phases. A negative length keeps the current setting so the
    // directed words above drain through the delay line. Each length stays
    // within the loaded taps.
    plan_len = '{-1, 2, 64, 0, 0};
    plan_cnt = '{40, 40, 45, 10, 55};
    plan_len[4] = $urandom_range(3, LOADED_TAPS);

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
      if (plan_len[p] >= 0) set_ir_length(plan_len[p]);
      // Short taps run fast; hold the receiver here so the block fills.
      if (p == 1) hold_req = 1'b1;
      n = 0;
      while (n < plan_cnt[p]) begin
        r = $urandom_range(0, 99);
        if (r < 74) begin
          send_word(OP_SAMPLE, TAP_AW'($urandom), SMP_W'($urandom), pick_q23());
          n++;
        end else if (r < 90) begin
          idx = $urandom_range(0, 1) ? TAP_AW'($urandom) : TAP_AW'($urandom_range(0, 63));
          send_word(OP_TAP, idx, pick_q23(), SMP_W'($urandom));
          n++;
        end else if (r < 93) begin
          send_word(OP_CLEAR, TAP_AW'($urandom), SMP_W'($urandom), SMP_W'($urandom));
          n++;
        end else begin
          // unused op: dropped by the block, not counted
          send_word(OP_UNUSED, TAP_AW'($urandom), SMP_W'($urandom), SMP_W'($urandom));
        end
      end
    end

    // Drain: wait for every expected word, then let stray output show up.
    in_w.valid <= 1'b0;
    while (words_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && words_pending == 0) begin
      $display("PASS impulse_response_convolver");
    end else begin
      $display("FAIL impulse_response_convolver");
    end
    $finish;
  end

endmodule
